// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// No dependencies; synthesis defines SYNTH to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_AFTER(label, clk, rst_n, a, n, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
        else $error("assertion failed");
`else
`define ASSERT_NOW(label, clk, rst_n, a, c)
`define ASSERT_AFTER(label, clk, rst_n, a, n, c)
`endif
`endif

// ===== sv/mbc2u16_pkg.sv =====
// Types and constants for the multibyte charset to UTF-16 decoder.
// No dependencies.
package mbc2u16_pkg;

    localparam int TABLE_DEPTH_DEF = 16384;
    localparam int IDX_W = 15;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [2:0] ENC_UTF16LE = 3'd0;
    localparam logic [2:0] ENC_UTF8    = 3'd1;
    localparam logic [2:0] ENC_BIG5    = 3'd2;
    localparam logic [2:0] ENC_GBK     = 3'd3;
    localparam logic [2:0] ENC_JIS     = 3'd4;

    localparam int ROW_LEN_BIG5 = 157;
    localparam int ROW_LEN_GBK  = 94;
    localparam int ROW_LEN_JIS  = 188;

    localparam logic [7:0] LEAD_ASCII_END = 8'h80;
    localparam logic [7:0] LEAD_A_LO      = 8'hA1;
    localparam logic [7:0] LEAD_A_HI      = 8'hC6;
    localparam logic [7:0] LEAD_B_LO      = 8'hC9;
    localparam logic [7:0] LEAD_B_HI      = 8'hF9;
    localparam logic [7:0] LEAD_B_BASE    = 8'hA3;
    localparam logic [7:0] GBK_A_HI       = 8'hA9;
    localparam logic [7:0] GBK_B_LO       = 8'hB0;
    localparam logic [7:0] GBK_B_HI       = 8'hF7;
    localparam logic [7:0] GBK_B_BASE     = 8'hA6;
    localparam logic [7:0] TRAIL_LO_LO    = 8'h40;
    localparam logic [7:0] TRAIL_LO_HI    = 8'h7E;
    localparam logic [7:0] TRAIL_HI_LO    = 8'hA1;
    localparam logic [7:0] TRAIL_HI_HI    = 8'hFE;
    localparam logic [7:0] TRAIL_HI_BASE  = 8'h62;
    localparam logic [7:0] TRAIL_MASK6    = 8'h3F;

    typedef enum logic [1:0] {
        LINE_BIG5 = 2'd0,
        LINE_GBK  = 2'd1,
        LINE_JIS  = 2'd2
    } line_t;

    typedef struct packed {
        logic        op;
        logic [13:0] table_index;
        logic [15:0] table_word;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [7:0]  third_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  bytes_used;
        logic        unmapped;
    } result_t;

    // after classify
    typedef struct packed {
        logic        valid;
        logic        is_write;
        logic        lookup;
        line_t       line;
        logic [6:0]  row;
        logic [7:0]  col;
        logic [15:0] code;    // direct code, or table word on a write
        logic [1:0]  used;
        logic        miss;
        logic [13:0] widx;
    } s1_t;

    // after index
    typedef struct packed {
        logic             valid;
        logic             is_write;
        logic             lookup;
        logic             addr_ok;
        logic [IDX_W-1:0] addr;
        logic [15:0]      code;
        logic [1:0]       used;
        logic             miss;
    } s2_t;

    // after table access
    typedef struct packed {
        logic        valid;
        logic        lookup;
        logic        addr_ok;
        logic [15:0] code;
        logic [1:0]  used;
        logic        miss;
    } s3_t;

endpackage

// ===== sv/multibyte_charset_to_utf16.sv =====
// Multibyte charset to UTF-16 decoder, top level.
// Depends on mbc2u16_pkg, mbc2u16_classify, mbc2u16_index, mbc2u16_table.
//
// Usage:
//   Drive item and raise start; the beat is taken at a clock edge with start
//   high and busy low. busy never rises, so one beat can enter every cycle.
//   op = write stores table_word at table_index (addresses at or beyond
//   TABLE_DEPTH are dropped) and gives no result. op = decode yields one
//   result beat: code_unit, bytes_used and unmapped, with done high for
//   exactly one cycle. The receiver cannot stall; results must be taken.
//   A decode passes four stages: classify, index multiply, table read, output.
//   Throughput: one beat per cycle, set by the single-port table, which
//   serves either one write or one read per beat.
//   cfg_we/cfg_wdata write the encoding register (0 UTF-16LE, 1 UTF-8,
//   2 BIG5, 3 GBK, 4 JIS); change it only while the pipeline is empty.
//   Reset sets the encoding to UTF-8 and empties the pipeline; table
//   contents are undefined until written, and no clearing pass runs.
`include "assert_macros.svh"
module multibyte_charset_to_utf16
    import mbc2u16_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  item_t      item,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    output logic       done,
    output result_t    result
);

    logic [2:0]  encoding_reg;
    s1_t         s1;
    s2_t         s2;
    s3_t         s3;
    logic [15:0] rdata;
    result_t     result_reg;
    result_t     result_next;
    logic        done_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_reg <= ENC_UTF8;
        end
        else if (cfg_we)
        begin
            encoding_reg <= cfg_wdata;
        end
    end

    mbc2u16_classify u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (start && !busy),
        .item     (item),
        .encoding (encoding_reg),
        .s1       (s1)
    );

    mbc2u16_index #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_index (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    mbc2u16_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .s2    (s2),
        .s3    (s3),
        .rdata (rdata)
    );

    always_comb
    begin
        result_next.bytes_used = s3.used;
        result_next.unmapped   = s3.miss;
        if (s3.lookup)
        begin
            // out-of-range table address reads as zero
            result_next.code_unit = s3.addr_ok ? rdata : 16'd0;
        end
        else
        begin
            result_next.code_unit = s3.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_AFTER(a_decode_gives_beat, clk, rst_n, start && !busy && item.op == OP_DECODE, 4, done)
    `ASSERT_AFTER(a_write_silent, clk, rst_n, start && !busy && item.op == OP_WRITE, 4, !done)
    `ASSERT_NOW(a_used_nonzero, clk, rst_n, done, result.bytes_used != 2'd0)
    `ASSERT_NOW(a_miss_shape, clk, rst_n, done && result.unmapped, result.code_unit == 16'd0 && result.bytes_used == 2'd2)

endmodule

// ===== sv/mbc2u16_classify.sv =====
// Stage 1: lead/trail range checks, direct decodes, table row and column.
// Depends on mbc2u16_pkg.
module mbc2u16_classify
    import mbc2u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  item_t      item,
    input  logic [2:0] encoding,
    output s1_t        s1
);

    s1_t s1_reg;
    s1_t s1_next;

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] diff_a;
    logic [7:0] diff_b;
    logic [7:0] diff_gb;
    logic [7:0] col_split;
    logic [7:0] col_gbk;
    logic [7:0] t_lo;
    logic [7:0] t_hi;
    logic [7:0] t_gbk;

    assign b0 = item.first_byte;
    assign b1 = item.second_byte;
    assign b2 = item.third_byte;
    assign diff_a  = b0 - LEAD_A_LO;
    assign diff_b  = b0 - LEAD_B_BASE;
    assign diff_gb = b0 - GBK_B_BASE;
    assign t_lo  = b1 - TRAIL_LO_LO;
    assign t_hi  = b1 - TRAIL_HI_BASE;
    assign t_gbk = b1 - TRAIL_HI_LO;

    always_comb
    begin
        if (b1 >= TRAIL_LO_LO && b1 <= TRAIL_LO_HI)
        begin
            col_split = t_lo;
        end
        else if (b1 >= TRAIL_HI_LO && b1 <= TRAIL_HI_HI)
        begin
            col_split = t_hi;
        end
        else
        begin
            col_split = 8'd0;
        end
        col_gbk = (b1 >= TRAIL_HI_LO && b1 <= TRAIL_HI_HI) ? t_gbk : 8'd0;
    end

    always_comb
    begin
        s1_next          = '0;
        s1_next.valid    = take;
        s1_next.is_write = (item.op == OP_WRITE);
        s1_next.widx     = item.table_index;
        s1_next.used     = 2'd2;
        s1_next.line     = LINE_BIG5;
        if (item.op == OP_WRITE)
        begin
            s1_next.code = item.table_word;
        end
        else
        begin
            unique case (encoding)
                ENC_UTF16LE:
                begin
                    s1_next.code = {b1, b0};
                end
                ENC_UTF8:
                begin
                    if (b0 < LEAD_ASCII_END)
                    begin
                        s1_next.code = {8'd0, b0};
                        s1_next.used = 2'd1;
                    end
                    else if (b0[5])
                    begin
                        s1_next.code = {b0[3:0], b1[5:0], b2[5:0]};
                        s1_next.used = 2'd3;
                    end
                    else
                    begin
                        s1_next.code = {5'd0, b0[4:0], b1[5:0]};
                    end
                end
                ENC_BIG5, ENC_JIS:
                begin
                    s1_next.line = (encoding == ENC_BIG5) ? LINE_BIG5 : LINE_JIS;
                    s1_next.col  = col_split;
                    if (b0 >= LEAD_A_LO && b0 <= LEAD_A_HI)
                    begin
                        s1_next.lookup = 1'b1;
                        s1_next.row    = diff_a[6:0];
                    end
                    else if (b0 >= LEAD_B_LO && b0 <= LEAD_B_HI)
                    begin
                        s1_next.lookup = 1'b1;
                        s1_next.row    = diff_b[6:0];
                    end
                    else if (b0 < LEAD_ASCII_END)
                    begin
                        s1_next.code = {8'd0, b0};
                        s1_next.used = 2'd1;
                    end
                    else
                    begin
                        s1_next.miss = 1'b1;
                    end
                end
                ENC_GBK:
                begin
                    s1_next.line = LINE_GBK;
                    s1_next.col  = col_gbk;
                    if (b0 >= LEAD_A_LO && b0 <= GBK_A_HI)
                    begin
                        s1_next.lookup = 1'b1;
                        s1_next.row    = diff_a[6:0];
                    end
                    else if (b0 >= GBK_B_LO && b0 <= GBK_B_HI)
                    begin
                        s1_next.lookup = 1'b1;
                        s1_next.row    = diff_gb[6:0];
                    end
                    else if (b0 < LEAD_ASCII_END)
                    begin
                        s1_next.code = {8'd0, b0};
                        s1_next.used = 2'd1;
                    end
                    else
                    begin
                        s1_next.miss = 1'b1;
                    end
                end
                default:
                begin
                    s1_next.miss = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

// ===== sv/mbc2u16_index.sv =====
// Stage 2: table index = row * row length + column (the write index on a write), bounds check.
// Depends on mbc2u16_pkg.
module mbc2u16_index
    import mbc2u16_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  s1_t  s1,
    output s2_t  s2
);

    s2_t s2_reg;
    s2_t s2_next;

    logic [IDX_W-1:0] prod;
    logic [IDX_W-1:0] idx;

    always_comb
    begin
        case (s1.line)
            LINE_BIG5: prod = IDX_W'(s1.row) * IDX_W'(ROW_LEN_BIG5);
            LINE_GBK:  prod = IDX_W'(s1.row) * IDX_W'(ROW_LEN_GBK);
            LINE_JIS:  prod = IDX_W'(s1.row) * IDX_W'(ROW_LEN_JIS);
            default:   prod = '0;
        endcase
        idx = s1.is_write ? IDX_W'(s1.widx) : prod + IDX_W'(s1.col);
    end

    always_comb
    begin
        s2_next          = '0;
        s2_next.valid    = s1.valid;
        s2_next.is_write = s1.is_write;
        s2_next.lookup   = s1.lookup;
        s2_next.addr     = idx;
        s2_next.addr_ok  = (32'(idx) < 32'(TABLE_DEPTH));
        s2_next.code     = s1.code;
        s2_next.used     = s1.used;
        s2_next.miss     = s1.miss;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

// ===== sv/mbc2u16_table.sv =====
// Stage 3: translation table, one write or one registered read per beat.
// Depends on mbc2u16_pkg.
module mbc2u16_table
    import mbc2u16_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  s2_t         s2,
    output s3_t         s3,
    output logic [15:0] rdata
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [15:0] mem [TABLE_DEPTH];
    logic [15:0] rdata_reg;
    s3_t         s3_reg;
    s3_t         s3_next;
    logic [31:0] addr_ext;
    logic [AW-1:0] mem_addr;

    assign addr_ext = 32'(s2.addr);
    assign mem_addr = addr_ext[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (s2.valid && s2.is_write && s2.addr_ok)
        begin
            mem[mem_addr] <= s2.code;
        end
        if (s2.valid && !s2.is_write && s2.lookup && s2.addr_ok)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        s3_next         = '0;
        s3_next.valid   = s2.valid && !s2.is_write;   // writes give no result
        s3_next.lookup  = s2.lookup;
        s3_next.addr_ok = s2.addr_ok;
        s3_next.code    = s2.code;
        s3_next.used    = s2.used;
        s3_next.miss    = s2.miss;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3    = s3_reg;
    assign rdata = rdata_reg;

endmodule
